### rtl/lifo_stack_with_swap_dup_core_assert.svh
// Assertion macros shared by the LIFO stack RTL.
`ifndef LIFO_STACK_WITH_SWAP_DUP_CORE_ASSERT_SVH
`define LIFO_STACK_WITH_SWAP_DUP_CORE_ASSERT_SVH

// Checks that an implication holds at every clock edge outside reset.
`define LSD_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LSD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/lsd_pkg.sv
// Package with the operation and status codes of the LIFO stack.
package lsd_pkg;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_SWAP  = 3'd4,
        OP_DUP   = 3'd5
    } op_kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOCLEAR = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FEW     = 3'd4
    } status_t;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 5;

endpackage

### rtl/lsd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/lifo_stack_with_swap_dup_core.sv
// Bounded LIFO stack with push, pop, peek, clear, swap and duplicate.
// The result is registered in the execute state and sent on from the done state; swap also
// passes S_SWAP_B and S_SWAP_C between them. A new operation is taken only while idle.
// The entry RAM gives one registered read and one write per cycle.
// Reset clears the depth and the handshake state; the entry RAM is not cleared.
// A result beat may wait in the output register while the next operation is taken.
module lifo_stack_with_swap_dup_core
    import lsd_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                kind,
    input  logic signed [DATA_W-1:0]  push_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                status,
    output logic signed [DATA_W-1:0]  data,
    output logic [DEPTH_W-1:0]        depth
);

`include "lifo_stack_with_swap_dup_core_assert.svh"

    // Address width of the entry RAM and width of the count, which must hold
    // the full depth itself.
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Sequencer states. The top entry is always read while idle, so it is on
    // the RAM output in the execute cycle. Swap reads the second entry in the
    // execute cycle and writes both entries back in S_SWAP_B and S_SWAP_C after it.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP_B,
        S_SWAP_C,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [CW-1:0]            count_reg;
    logic                     out_valid_reg;
    logic [2:0]               status_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic [DEPTH_W-1:0]       depth_reg;

    // Operation held while it executes, and the result held until the output
    // register is free.
    logic [2:0]               kind_reg;
    logic [DATA_W-1:0]        value_reg;
    logic [DATA_W-1:0]        tmp_reg;
    status_t                  res_status_reg;
    logic [DATA_W-1:0]        res_data_reg;
    status_t                  res_status_next;
    logic [DATA_W-1:0]        res_data_next;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [DATA_W-1:0]        mem_rdata;

    logic                     is_empty;
    logic                     is_full;
    logic                     out_free;
    logic [CW-1:0]            count_m1;
    logic [CW-1:0]            count_m2;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(STACK_DEPTH));
    assign out_free = !out_valid_reg || out_ready;
    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign depth     = depth_reg;

    // RAM port control. While idle the read address tracks the top entry.
    // The address of an empty stack wraps, and that word is never used.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = value_reg;
        mem_raddr = count_m1[AW-1:0];
        case (state_reg)
            S_EXEC:
            begin
                mem_raddr = count_m2[AW-1:0];
                if (kind_reg == OP_PUSH)
                begin
                    mem_we = !is_full;
                end
                else if (kind_reg == OP_DUP)
                begin
                    // Duplicating an empty stack pushes a zero.
                    mem_we    = !is_full;
                    mem_wdata = is_empty ? '0 : mem_rdata;
                end
            end
            S_SWAP_B:
            begin
                // The second entry is on the RAM output; it moves to the top.
                mem_we    = 1'b1;
                mem_waddr = count_m1[AW-1:0];
                mem_wdata = mem_rdata;
            end
            S_SWAP_C:
            begin
                mem_we    = 1'b1;
                mem_waddr = count_m2[AW-1:0];
                mem_wdata = tmp_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    lsd_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_entries (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Result of the operation in the execute cycle, where the top entry is on
    // the RAM output.
    always_comb
    begin
        res_status_next = ST_OK;
        res_data_next   = '0;
        case (kind_reg)
            OP_PUSH:
            begin
                if (is_full)
                begin
                    res_status_next = ST_FULL;
                end
            end
            OP_POP:
            begin
                if (is_empty)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    res_data_next = mem_rdata;
                end
            end
            OP_PEEK:
            begin
                if (!is_empty)
                begin
                    res_data_next = mem_rdata;
                end
            end
            OP_CLEAR:
            begin
                if (is_empty)
                begin
                    res_status_next = ST_NOCLEAR;
                end
            end
            OP_SWAP:
            begin
                if (count_reg < CW'(2))
                begin
                    res_status_next = ST_FEW;
                end
            end
            OP_DUP:
            begin
                if (is_full)
                begin
                    res_status_next = ST_FULL;
                end
            end
            default:
            begin
                res_status_next = ST_OK;
            end
        endcase
    end

    // Operation and result payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= kind;
            value_reg <= push_value;
        end
        if (state_reg == S_EXEC)
        begin
            tmp_reg        <= mem_rdata;
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
        end
    end

    // Sequencer, depth count and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            data_reg      <= '0;
            depth_reg     <= '0;
        end
        else
        begin
            // In the done state the output register is refilled below instead.
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    // Swap with at least two entries goes on to its write-back cycles.
                    if (kind_reg == OP_SWAP && count_reg >= CW'(2))
                    begin
                        state_reg <= S_SWAP_B;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                    case (kind_reg)
                        OP_PUSH, OP_DUP:
                        begin
                            if (!is_full)
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (!is_empty)
                            begin
                                count_reg <= count_m1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            // Entries above the count are never read, so the
                            // RAM itself needs no clearing.
                            count_reg <= '0;
                        end
                        default:
                        begin
                            // Peek, swap and the unused codes keep the count.
                            count_reg <= count_reg;
                        end
                    endcase
                end
                S_SWAP_B:
                begin
                    state_reg <= S_SWAP_C;
                end
                S_SWAP_C:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        data_reg      <= res_data_reg;
                        depth_reg     <= DEPTH_W'(count_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The count never runs past the capacity of the entry RAM.
    `LSD_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CW'(STACK_DEPTH),
        "stack count exceeds capacity")

    // A taken input beat always starts execution in the next cycle.
    `LSD_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_reg == S_EXEC,
        "accepted operation did not start execution")

    // The count only changes as the result of the execute cycle.
    `LSD_ASSERT_NEXT(a_count_stable, state_reg != S_EXEC, $stable(count_reg),
        "stack count changed outside the execute cycle")

    // A push onto a stack with room writes the RAM and grows the count by one.
    `LSD_ASSERT_NEXT(a_push_grows,
        state_reg == S_EXEC && kind_reg == OP_PUSH && !is_full,
        $past(mem_we) && count_reg == $past(count_reg) + CW'(1),
        "push did not write the entry and grow the count")

endmodule
